>>> rtl/evm_pkg.sv
package evm_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int TRIG_STEPS    = 16;
  localparam int TRIG_ITERS    = (TRIG_STEPS + 1) / 2;
  localparam int ITER_W        = $clog2(TRIG_ITERS + 1);

  typedef logic signed [31:0] word_t;
  typedef logic signed [63:0] prod_t;

  localparam word_t CORDIC_GAIN = 32'sh26DD3B6A;
  localparam word_t ONE         = word_t'(64'sd1 <<< FRACTION_BITS);

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
  } rot_t;

  typedef struct packed {
    word_t co;
    word_t si;
  } cs_t;

  typedef struct packed {
    word_t pos_x;
    word_t pos_y;
    word_t pos_z;
    word_t c1;
    word_t s1;
    word_t c2;
    word_t s2;
    word_t c3;
    word_t s3;
  } job_t;

  typedef struct packed {
    word_t [2:0] u;
    word_t [2:0] v;
    word_t [2:0] w;
    word_t [2:0] t;
    word_t [2:0] p;
  } frame_t;

  typedef enum logic [3:0] {
    ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_BASIS, ST_DOT_U, ST_DOT_V, ST_DOT_W, ST_T2
  } step_t;

  function automatic word_t atan_turn(input logic [4:0] i);
    word_t a;
    case (i)
      5'd0:    a = 32'sh20000000;
      5'd1:    a = 32'sh12E4051E;
      5'd2:    a = 32'sh09FB385B;
      5'd3:    a = 32'sh051111D4;
      5'd4:    a = 32'sh028B0D43;
      5'd5:    a = 32'sh0145D7E1;
      5'd6:    a = 32'sh00A2F61E;
      5'd7:    a = 32'sh00517C55;
      5'd8:    a = 32'sh0028BE53;
      5'd9:    a = 32'sh00145F2F;
      5'd10:   a = 32'sh000A2F98;
      5'd11:   a = 32'sh000517CC;
      5'd12:   a = 32'sh00028BE6;
      5'd13:   a = 32'sh000145F3;
      5'd14:   a = 32'sh0000A2FA;
      5'd15:   a = 32'sh0000517D;
      5'd16:   a = 32'sh000028BE;
      5'd17:   a = 32'sh0000145F;
      5'd18:   a = 32'sh00000A30;
      5'd19:   a = 32'sh00000518;
      5'd20:   a = 32'sh0000028C;
      5'd21:   a = 32'sh00000146;
      5'd22:   a = 32'sh000000A3;
      5'd23:   a = 32'sh00000051;
      default: a = 32'sh0;
    endcase
    return a;
  endfunction

  function automatic rot_t cordic_step(input rot_t r, input logic [4:0] i);
    word_t dx;
    word_t dy;
    rot_t  o;
    dx = r.y >>> i;
    dy = r.x >>> i;
    if (!r.z[31]) begin
      o.x = r.x - dx;
      o.y = r.y + dy;
      o.z = r.z - atan_turn(i);
    end else begin
      o.x = r.x + dx;
      o.y = r.y - dy;
      o.z = r.z + atan_turn(i);
    end
    return o;
  endfunction

  function automatic cs_t quad_map(input rot_t r, input logic [1:0] q);
    cs_t o;
    case (q)
      2'd0:    begin o.co = r.x;  o.si = r.y;  end
      2'd1:    begin o.co = -r.y; o.si = r.x;  end
      2'd2:    begin o.co = -r.x; o.si = -r.y; end
      default: begin o.co = r.y;  o.si = -r.x; end
    endcase
    return o;
  endfunction

  function automatic word_t rnd30(input prod_t p);
    prod_t s;
    prod_t t;
    s = p + (64'sd1 <<< 29);
    t = s >>> 30;
    return t[31:0];
  endfunction

  function automatic word_t q30_to_out(input logic signed [32:0] v);
    logic signed [32:0] s;
    logic signed [32:0] t;
    s = v + (33'sd1 <<< (29 - FRACTION_BITS));
    t = s >>> (30 - FRACTION_BITS);
    return t[31:0];
  endfunction

  function automatic word_t neg_dot_sat(input prod_t a, input prod_t b, input prod_t c);
    logic signed [66:0] s;
    logic signed [66:0] r;
    word_t o;
    s = 67'(a) + 67'(b) + 67'(c) + (67'sd1 <<< (FRACTION_BITS - 1));
    r = -(s >>> FRACTION_BITS);
    if (r > 67'sd2147483647) begin
      o = 32'sh7FFFFFFF;
    end else if (r < -67'sd2147483648) begin
      o = 32'sh80000000;
    end else begin
      o = r[31:0];
    end
    return o;
  endfunction

endpackage

>>> rtl/euler_yxz_view_matrix.sv
// Each camera update given with start while busy is low yields eight column beats, view
// matrix columns 0 to 3 and then inverse columns 0 to 3, each on the outputs for one cycle
// with strobe high; the receiver cannot stall them. The sine and cosine front end keeps
// busy high until it has pushed its job into the two-deep queue that follows, and the
// back end works each job through its three shared multipliers, taking the next job from
// the queue only once the emitter has taken the frame of the last one.
module euler_yxz_view_matrix (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  evm_pkg::word_t pos_x,
  input  evm_pkg::word_t pos_y,
  input  evm_pkg::word_t pos_z,
  input  logic signed [15:0] angle_x,
  input  logic signed [15:0] angle_y,
  input  logic signed [15:0] angle_z,
  output logic           strobe,
  output logic           which_matrix,
  output logic [1:0]     column,
  output evm_pkg::word_t entry_row0,
  output evm_pkg::word_t entry_row1,
  output evm_pkg::word_t entry_row2,
  output evm_pkg::word_t entry_row3,
  output logic           last_of_run
);
  import evm_pkg::*;

  job_t   front_job, queue_job;
  frame_t frame;
  logic   push, pop, full, empty, load, emit_ready;

  evm_front u_front (
    .clk(clk), .rst(rst), .start(start),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
    .full(full), .busy(busy), .push(push), .job(front_job)
  );

  evm_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata(front_job),
    .pop(pop), .rdata(queue_job), .full(full), .empty(empty)
  );

  evm_back u_back (
    .clk(clk), .rst(rst), .empty(empty), .job(queue_job),
    .emit_ready(emit_ready), .pop(pop), .load(load), .frame(frame)
  );

  evm_emit u_emit (
    .clk(clk), .rst(rst), .load(load), .frame(frame), .ready(emit_ready),
    .strobe(strobe), .which_matrix(which_matrix), .column(column),
    .entry_row0(entry_row0), .entry_row1(entry_row1),
    .entry_row2(entry_row2), .entry_row3(entry_row3),
    .last_of_run(last_of_run)
  );

endmodule

>>> rtl/evm_front.sv
module evm_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  evm_pkg::word_t pos_x,
  input  evm_pkg::word_t pos_y,
  input  evm_pkg::word_t pos_z,
  input  logic [15:0]   angle_x,
  input  logic [15:0]   angle_y,
  input  logic [15:0]   angle_z,
  input  logic          full,
  output logic          busy,
  output logic          push,
  output evm_pkg::job_t job
);
  import evm_pkg::*;

  logic              active;
  logic [ITER_W-1:0] iter;
  rot_t              r [3];
  rot_t              r_next [3];
  logic [1:0]        quad [3];
  word_t             px, py, pz;
  logic [15:0]       ang [3];
  logic [4:0]        idx0, idx1;
  cs_t               cs [3];
  logic              finished;

  // Lane 0 carries angle_y, lane 1 angle_x and lane 2 angle_z.
  assign ang[0] = angle_y;
  assign ang[1] = angle_x;
  assign ang[2] = angle_z;

  assign idx0     = 5'(iter) << 1;
  assign idx1     = idx0 + 5'd1;
  assign finished = (iter == ITER_W'(TRIG_ITERS));
  assign busy     = active;
  assign push     = active && finished && !full;

  // Two rotations per cycle; the second is skipped past the last step.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      r_next[k] = cordic_step(r[k], idx0);
      if (32'(idx1) < TRIG_STEPS) begin
        r_next[k] = cordic_step(r_next[k], idx1);
      end
      cs[k] = quad_map(r[k], quad[k]);
    end
  end

  always_comb begin
    job.pos_x = px;
    job.pos_y = py;
    job.pos_z = pz;
    job.c1    = cs[0].co;
    job.s1    = cs[0].si;
    job.c2    = cs[1].co;
    job.s2    = cs[1].si;
    job.c3    = cs[2].co;
    job.s3    = cs[2].si;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      iter   <= '0;
    end else if (start && !busy) begin
      active <= 1'b1;
      iter   <= '0;
    end else if (active && !finished) begin
      iter <= iter + ITER_W'(1);
    end else if (push) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      px <= pos_x;
      py <= pos_y;
      pz <= pos_z;
      for (int k = 0; k < 3; k++) begin
        r[k].x  <= CORDIC_GAIN;
        r[k].y  <= '0;
        r[k].z  <= word_t'({ang[k][13:0], 16'b0});
        quad[k] <= ang[k][15:14];
      end
    end else if (active && !finished) begin
      for (int k = 0; k < 3; k++) begin
        r[k] <= r_next[k];
      end
    end
  end

endmodule

>>> rtl/evm_queue.sv
module evm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  evm_pkg::job_t wdata,
  input  logic          pop,
  output evm_pkg::job_t rdata,
  output logic          full,
  output logic          empty
);
  import evm_pkg::*;

  job_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

>>> rtl/evm_back.sv
module evm_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            empty,
  input  evm_pkg::job_t   job,
  input  logic            emit_ready,
  output logic            pop,
  output logic            load,
  output evm_pkg::frame_t frame
);
  import evm_pkg::*;

  logic   active;
  logic   active_next;
  step_t  step;
  step_t  step_next;
  logic   advance;
  job_t   j;
  word_t  ma [3];
  word_t  mb [3];
  prod_t  prod [3];
  word_t  s1s2, c1s2, c1c3, c2s3, c3s1, c1s3, c2c3, s1s3, c2s1, c1c2, s1s2s3, s1s2c3;
  word_t  c1s2s3, c1s2c3;
  word_t  [2:0] u, v, w;
  word_t  t0, t1;

  assign pop     = !active && !empty;
  assign advance = active && !(step == ST_T2 && !emit_ready);
  assign load    = advance && step == ST_T2;

  always_comb begin
    frame.u = u;
    frame.v = v;
    frame.w = w;
    frame.t = {neg_dot_sat(prod[0], prod[1], prod[2]), t1, t0};
    frame.p = {j.pos_z, j.pos_y, j.pos_x};
  end

  // Three multipliers are shared over the schedule below.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ma[k] = '0;
      mb[k] = '0;
    end
    case (step)
      ST_P0: begin
        ma[0] = j.s1; mb[0] = j.s2;
        ma[1] = j.c1; mb[1] = j.s2;
        ma[2] = j.c1; mb[2] = j.c3;
      end
      ST_P1: begin
        ma[0] = j.c2; mb[0] = j.s3;
        ma[1] = j.c3; mb[1] = j.s1;
        ma[2] = j.c1; mb[2] = j.s3;
      end
      ST_P2: begin
        ma[0] = j.c2; mb[0] = j.c3;
        ma[1] = j.s1; mb[1] = j.s3;
        ma[2] = j.c2; mb[2] = j.s1;
      end
      ST_P3: begin
        ma[0] = j.c1; mb[0] = j.c2;
        ma[1] = s1s2; mb[1] = j.s3;
        ma[2] = s1s2; mb[2] = j.c3;
      end
      ST_P4: begin
        ma[0] = c1s2; mb[0] = j.s3;
        ma[1] = c1s2; mb[1] = j.c3;
      end
      ST_DOT_U: begin
        ma[0] = u[0]; mb[0] = j.pos_x;
        ma[1] = u[1]; mb[1] = j.pos_y;
        ma[2] = u[2]; mb[2] = j.pos_z;
      end
      ST_DOT_V: begin
        ma[0] = v[0]; mb[0] = j.pos_x;
        ma[1] = v[1]; mb[1] = j.pos_y;
        ma[2] = v[2]; mb[2] = j.pos_z;
      end
      ST_DOT_W: begin
        ma[0] = w[0]; mb[0] = j.pos_x;
        ma[1] = w[1]; mb[1] = j.pos_y;
        ma[2] = w[2]; mb[2] = j.pos_z;
      end
      default: ;
    endcase
  end

  always_comb begin
    active_next = active;
    step_next   = step;
    if (pop) begin
      active_next = 1'b1;
      step_next   = ST_P0;
    end else if (advance) begin
      if (step == ST_T2) begin
        active_next = 1'b0;
      end else begin
        step_next = step_t'(step + 4'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      step   <= ST_P0;
    end else begin
      active <= active_next;
      step   <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      j <= job;
    end
    if (advance) begin
      for (int k = 0; k < 3; k++) begin
        prod[k] <= prod_t'(ma[k]) * prod_t'(mb[k]);
      end
      case (step)
        ST_P1: begin
          s1s2 <= rnd30(prod[0]);
          c1s2 <= rnd30(prod[1]);
          c1c3 <= rnd30(prod[2]);
        end
        ST_P2: begin
          c2s3 <= rnd30(prod[0]);
          c3s1 <= rnd30(prod[1]);
          c1s3 <= rnd30(prod[2]);
        end
        ST_P3: begin
          c2c3 <= rnd30(prod[0]);
          s1s3 <= rnd30(prod[1]);
          c2s1 <= rnd30(prod[2]);
        end
        ST_P4: begin
          c1c2   <= rnd30(prod[0]);
          s1s2s3 <= rnd30(prod[1]);
          s1s2c3 <= rnd30(prod[2]);
        end
        ST_BASIS: begin
          u[0] <= q30_to_out(33'(c1c3) + 33'(s1s2s3));
          u[1] <= q30_to_out(33'(c2s3));
          u[2] <= q30_to_out(33'(c1s2s3) - 33'(c3s1));
          v[0] <= q30_to_out(33'(s1s2c3) - 33'(c1s3));
          v[1] <= q30_to_out(33'(c2c3));
          v[2] <= q30_to_out(33'(c1s2c3) + 33'(s1s3));
          w[0] <= q30_to_out(33'(c2s1));
          w[1] <= q30_to_out(-33'(j.s2));
          w[2] <= q30_to_out(33'(c1c2));
        end
        ST_DOT_V: begin
          t0 <= neg_dot_sat(prod[0], prod[1], prod[2]);
        end
        ST_DOT_W: begin
          t1 <= neg_dot_sat(prod[0], prod[1], prod[2]);
        end
        default: ;
      endcase
    end
  end

  assign c1s2s3 = rnd30(prod[0]);
  assign c1s2c3 = rnd30(prod[1]);

endmodule

>>> rtl/evm_emit.sv
module evm_emit (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  evm_pkg::frame_t frame,
  output logic            ready,
  output logic            strobe,
  output logic            which_matrix,
  output logic [1:0]      column,
  output evm_pkg::word_t  entry_row0,
  output evm_pkg::word_t  entry_row1,
  output evm_pkg::word_t  entry_row2,
  output evm_pkg::word_t  entry_row3,
  output logic            last_of_run
);
  import evm_pkg::*;

  logic       active;
  logic [2:0] k;
  frame_t     f;
  word_t      r0, r1, r2, r3;

  assign ready = !active || k == 3'd7;

  always_comb begin
    r0 = '0;
    r1 = '0;
    r2 = '0;
    r3 = '0;
    case (k)
      3'd0:    begin r0 = f.u[0]; r1 = f.v[0]; r2 = f.w[0]; end
      3'd1:    begin r0 = f.u[1]; r1 = f.v[1]; r2 = f.w[1]; end
      3'd2:    begin r0 = f.u[2]; r1 = f.v[2]; r2 = f.w[2]; end
      3'd3:    begin r0 = f.t[0]; r1 = f.t[1]; r2 = f.t[2]; r3 = ONE; end
      3'd4:    begin r0 = f.u[0]; r1 = f.u[1]; r2 = f.u[2]; end
      3'd5:    begin r0 = f.v[0]; r1 = f.v[1]; r2 = f.v[2]; end
      3'd6:    begin r0 = f.w[0]; r1 = f.w[1]; r2 = f.w[2]; end
      default: begin r0 = f.p[0]; r1 = f.p[1]; r2 = f.p[2]; r3 = ONE; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      k      <= 3'd0;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (load) begin
        active <= 1'b1;
        k      <= 3'd0;
      end else if (active) begin
        k <= k + 3'd1;
        if (k == 3'd7) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      f <= frame;
    end
    which_matrix <= k[2];
    column       <= k[1:0];
    last_of_run  <= (k == 3'd7);
    entry_row0   <= r0;
    entry_row1   <= r1;
    entry_row2   <= r2;
    entry_row3   <= r3;
  end

endmodule

>>> tb/euler_yxz_view_matrix_test.sv
`timescale 1ns / 1ps

import evm_pkg::*;

typedef struct {
  logic       which;
  logic [1:0] col;
  word_t      r0;
  word_t      r1;
  word_t      r2;
  word_t      r3;
  logic       last;
} column_beat_t;

class column_scoreboard;
  column_beat_t pending_columns[$];
  int           errors;

  static function automatic longint asr(longint v, int n);
    return v >>> n;
  endfunction

  static function automatic void trig(logic [15:0] ang, output longint co, output longint si);
    longint x, y, z, dx, dy;
    longint steps[24] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
      'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
      'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
      'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051};
    x = 'h26DD3B6A;
    y = 0;
    z = longint'(ang[13:0]) << 16;
    for (int i = 0; i < TRIG_STEPS && i < 24; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= steps[i];
      end else begin
        x += dx; y -= dy; z += steps[i];
      end
    end
    case (ang[15:14])
      2'd0: begin co = x;  si = y;  end
      2'd1: begin co = -y; si = x;  end
      2'd2: begin co = -x; si = -y; end
      default: begin co = y; si = -x; end
    endcase
  endfunction

  static function automatic longint m30(longint a, longint b);
    return asr(a * b + (64'sd1 <<< 29), 30);
  endfunction

  static function automatic longint to_q(longint v);
    return asr(v + (64'sd1 <<< (29 - FRACTION_BITS)), 30 - FRACTION_BITS);
  endfunction

  // The sum of three products is carried at 68 bits.
  static function automatic word_t translation(longint b[3], longint p[3]);
    logic signed [67:0] s, r;
    s = 68'(b[0]) * 68'(p[0]) + 68'(b[1]) * 68'(p[1]) + 68'(b[2]) * 68'(p[2]);
    r = -((s + (68'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS);
    if (r > 68'sd2147483647) return 32'sh7FFFFFFF;
    if (r < -68'sd2147483648) return 32'sh80000000;
    return r[31:0];
  endfunction

  function void push(logic w, logic [1:0] c, word_t a, word_t b, word_t d, word_t e,
                     logic l);
    column_beat_t cb;
    cb.which = w; cb.col = c; cb.r0 = a; cb.r1 = b; cb.r2 = d; cb.r3 = e; cb.last = l;
    pending_columns.push_back(cb);
  endfunction

  function void note_camera(word_t px, word_t py, word_t pz,
                            logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
    longint c1, s1, c2, s2, c3, s3, s1s2, c1s2;
    longint u[3], v[3], w[3], p[3];
    word_t t[3];
    p[0] = longint'(px); p[1] = longint'(py); p[2] = longint'(pz);
    trig(ay, c1, s1);
    trig(ax, c2, s2);
    trig(az, c3, s3);
    s1s2 = m30(s1, s2);
    c1s2 = m30(c1, s2);
    u[0] = to_q(m30(c1, c3) + m30(s1s2, s3));
    u[1] = to_q(m30(c2, s3));
    u[2] = to_q(m30(c1s2, s3) - m30(c3, s1));
    v[0] = to_q(m30(s1s2, c3) - m30(c1, s3));
    v[1] = to_q(m30(c2, c3));
    v[2] = to_q(m30(c1s2, c3) + m30(s1, s3));
    w[0] = to_q(m30(c2, s1));
    w[1] = to_q(-s2);
    w[2] = to_q(m30(c1, c2));
    t[0] = translation(u, p);
    t[1] = translation(v, p);
    t[2] = translation(w, p);
    for (int k = 0; k < 3; k++)
      push(1'b0, 2'(k), word_t'(u[k]), word_t'(v[k]), word_t'(w[k]), word_t'(0), 1'b0);
    push(1'b0, 2'd3, t[0], t[1], t[2], ONE, 1'b0);
    push(1'b1, 2'd0, word_t'(u[0]), word_t'(u[1]), word_t'(u[2]), word_t'(0), 1'b0);
    push(1'b1, 2'd1, word_t'(v[0]), word_t'(v[1]), word_t'(v[2]), word_t'(0), 1'b0);
    push(1'b1, 2'd2, word_t'(w[0]), word_t'(w[1]), word_t'(w[2]), word_t'(0), 1'b0);
    push(1'b1, 2'd3, px, py, pz, ONE, 1'b1);
  endfunction

  function void report(string what, longint got, longint want);
    $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
    errors++;
  endfunction

  function void check_column(logic w, logic [1:0] c, word_t a, word_t b, word_t d,
                             word_t e, logic l);
    column_beat_t x;
    if (pending_columns.size() == 0) begin
      report("unexpected beat", 0, 0);
      return;
    end
    x = pending_columns.pop_front();
    if (w !== x.which) report("which_matrix", longint'(w), longint'(x.which));
    if (c !== x.col)   report("column", longint'(c), longint'(x.col));
    if (a !== x.r0)    report("entry_row0", longint'(a), longint'(x.r0));
    if (b !== x.r1)    report("entry_row1", longint'(b), longint'(x.r1));
    if (d !== x.r2)    report("entry_row2", longint'(d), longint'(x.r2));
    if (e !== x.r3)    report("entry_row3", longint'(e), longint'(x.r3));
    if (l !== x.last)  report("last_of_run", longint'(l), longint'(x.last));
  endfunction
endclass

module euler_yxz_view_matrix_test;
  logic clk = 0, rst = 1, start = 0;
  logic busy, strobe, which_matrix, last_of_run;
  logic [1:0] column;
  word_t pos_x = 0, pos_y = 0, pos_z = 0;
  logic signed [15:0] angle_x = 0, angle_y = 0, angle_z = 0;
  word_t entry_row0, entry_row1, entry_row2, entry_row3;
  int idle_pct;
  longint cycles;
  column_scoreboard board = new();

  euler_yxz_view_matrix dut (.*);

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (!rst && strobe)
      board.check_column(which_matrix, column, entry_row0, entry_row1, entry_row2,
                         entry_row3, last_of_run);
    if (cycles > 200000) begin
      $display("euler_yxz_view_matrix test failed");
      $finish;
    end
  end

  function automatic word_t rand_pos();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return word_t'($urandom_range(0, 'h7FFFF) - 'h40000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'(16'h4000 * $urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  // Start stays high between back-to-back beats and drops only while the sender idles.
  task automatic send_camera(word_t px, word_t py, word_t pz, logic [15:0] ax,
                             logic [15:0] ay, logic [15:0] az);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    pos_x <= px; pos_y <= py; pos_z <= pz;
    angle_x <= ax; angle_y <= ay; angle_z <= az;
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_camera(px, py, pz, ax, ay, az);
    @(negedge clk);
  endtask

  initial begin
    logic [15:0] special[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                16'h7FFF, 16'h3FFF, 16'hFFFF, 16'h2000};
    idle_pct = 0;
    repeat (12) @(negedge clk);
    rst <= 0;
    // Quadrant boundaries and wrap points, with positions of 0, +1.0 and -1.0.
    for (int i = 0; i < 8; i++)
      send_camera(0, 32'sh00010000, -32'sh00010000, special[i], special[(i + 3) % 8],
                  special[(i + 5) % 8]);
    // Saturating translations: large positions of both signs.
    send_camera(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'h0000, 16'h0000, 16'h0000);
    send_camera(32'sh80000000, 32'sh80000000, 32'sh80000000, 16'h0000, 16'h0000, 16'h0000);
    send_camera(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 16'h2000, 16'h2000, 16'h2000);
    send_camera(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 16'hE000, 16'h6000, 16'hA000);
    send_camera(32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA, 16'h5555, 16'hAAAA, 16'hFFFF);
    // The sender holds off until the block has emitted everything outstanding.
    start <= 0;
    do @(negedge clk); while (board.pending_columns.size() != 0);
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 1) ? 70 : (ph == 2) ? 17 : 0;
      for (int n = 0; n < 37; n++)
        send_camera(rand_pos(), rand_pos(), rand_pos(), rand_angle(), rand_angle(),
                    rand_angle());
    end
    start <= 0;
    do @(negedge clk); while (board.pending_columns.size() != 0);
    repeat (40) @(negedge clk);
    if (board.errors == 0)
      $display("euler_yxz_view_matrix test passed");
    else
      $display("euler_yxz_view_matrix test failed");
    $finish;
  end
endmodule
